[rtl/core/xrg_pkg.sv]
// Shared types, constants and command encodings of the xoshiro256** generator.
package xrg_pkg;

  localparam int WORD_W    = 64;
  localparam int NWORDS    = 4;
  localparam int WIDX_W    = $clog2(NWORDS);
  localparam int MAX_DRAWS = 64;
  localparam int TRY_W     = $clog2(MAX_DRAWS + 1);
  localparam int DIV_STEPS = WORD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] SM_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] SM_MUL_B = 64'h94d049bb133111eb;
  localparam int SHIFT_S3 = 17;
  localparam int ROT_S3   = 45;

  typedef enum logic [1:0] {
    ACT_SEED  = 2'd0,
    ACT_RAW   = 2'd1,
    ACT_BOUND = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_SM_ADD,
    CMD_MUL0,
    CMD_MUL1,
    CMD_MUL2,
    CMD_DRAW,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_LIM_SAVE,
    CMD_OUT
  } cmd_op_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_RAW,
    OUT_REM
  } out_sel_t;

  typedef enum logic {
    DIV_NEG_N,
    DIV_DRAW
  } div_src_t;

  typedef struct packed {
    cmd_op_t             op;
    logic                csel;
    logic [WIDX_W-1:0]   widx;
    div_src_t            dsrc;
    out_sel_t            osel;
    logic                err;
  } cmd_t;

  typedef struct packed {
    logic op_zero;
    logic x_ge_lim;
  } status_t;

endpackage

[rtl/core/xrg_rem.sv]
// Restoring remainder unit, one quotient bit per cycle while step is asserted.
module xrg_rem (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic [xrg_pkg::WORD_W-1:0] dividend,
  input  logic [xrg_pkg::WORD_W-1:0] divisor,
  output logic [xrg_pkg::WORD_W-1:0] rem
);
  import xrg_pkg::*;

  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dq_r, dq_nxt;
  logic [WORD_W:0]   trial;

  assign trial = {rem_r, dq_r[WORD_W-1]};

  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    if (start) begin
      rem_nxt = '0;
      dq_nxt  = dividend;
    end else if (step) begin
      dq_nxt = {dq_r[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = WORD_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign rem = rem_r;

endmodule

[rtl/core/xrg_datapath.sv]
// Datapath: state words, splitmix multiply, raw draw, remainder unit, result register.
module xrg_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  xrg_pkg::cmd_t              cmd,
  input  logic [xrg_pkg::WORD_W-1:0] operand,
  output xrg_pkg::status_t           status,
  output logic [xrg_pkg::WORD_W-1:0] out_value,
  output logic                       out_error
);
  import xrg_pkg::*;

  logic [WORD_W-1:0] s_r [NWORDS];
  logic [WORD_W-1:0] op_r, acc_r, z_r, p_r, x_r, lim_r;
  logic [WORD_W-1:0] value_r;
  logic              err_r;

  logic [WORD_W-1:0] sm_sum, mconst, mix, rem, div_src;
  logic [31:0]       mul_a, mul_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] t1, rt, draw;
  logic [WORD_W-1:0] s2x, s3x, s1n, s0n, s2n, s3n;

  assign sm_sum = acc_r + SM_GAMMA;
  assign mconst = cmd.csel ? SM_MUL_B : SM_MUL_A;

  always_comb begin
    mul_a = z_r[31:0];
    mul_b = mconst[31:0];
    case (cmd.op)
      CMD_MUL1: mul_a = z_r[63:32];
      CMD_MUL2: mul_b = mconst[63:32];
      default:  mul_a = z_r[31:0];
    endcase
  end

  assign prod = {32'b0, mul_a} * {32'b0, mul_b};
  assign mix  = p_r + {prod[31:0], 32'b0};

  assign t1   = s_r[1] + {s_r[1][WORD_W-3:0], 2'b0};
  assign rt   = {t1[WORD_W-8:0], t1[WORD_W-1:WORD_W-7]};
  assign draw = rt + {rt[WORD_W-4:0], 3'b0};

  assign s2x = s_r[2] ^ s_r[0];
  assign s3x = s_r[3] ^ s_r[1];
  assign s1n = s_r[1] ^ s2x;
  assign s0n = s_r[0] ^ s3x;
  assign s2n = s2x ^ (s_r[1] << SHIFT_S3);
  assign s3n = (s3x << ROT_S3) | (s3x >> (WORD_W - ROT_S3));

  assign div_src = (cmd.dsrc == DIV_DRAW) ? x_r : WORD_W'(64'd0 - op_r);

  xrg_rem u_rem (
    .clk      (clk),
    .start    (cmd.op == CMD_DIV_START),
    .step     (cmd.op == CMD_DIV_STEP),
    .dividend (div_src),
    .divisor  (op_r),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NWORDS; i++) begin
        s_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        CMD_DRAW: begin
          s_r[0] <= s0n;
          s_r[1] <= s1n;
          s_r[2] <= s2n;
          s_r[3] <= s3n;
        end
        CMD_MUL2: begin
          if (cmd.csel) begin
            s_r[cmd.widx] <= mix ^ (mix >> 31);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        op_r  <= operand;
        acc_r <= operand;
      end
      CMD_SM_ADD: begin
        acc_r <= sm_sum;
        z_r   <= sm_sum ^ (sm_sum >> 30);
      end
      CMD_MUL0: p_r <= prod;
      CMD_MUL1: p_r <= mix;
      CMD_MUL2: z_r <= mix ^ (mix >> 27);
      CMD_DRAW: x_r <= draw;
      CMD_LIM_SAVE: lim_r <= rem;
      CMD_OUT: begin
        err_r <= cmd.err;
        case (cmd.osel)
          OUT_RAW: value_r <= x_r;
          OUT_REM: value_r <= rem;
          default: value_r <= '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign status.op_zero  = (op_r == '0);
  assign status.x_ge_lim = (x_r >= lim_r);
  assign out_value       = value_r;
  assign out_error       = err_r;

endmodule

[rtl/core/xrg_ctrl.sv]
// Controller: sequences seeding, draws, rejection and remainder steps.
module xrg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  xrg_pkg::act_t    action,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  xrg_pkg::status_t status,
  output xrg_pkg::cmd_t    cmd
);
  import xrg_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SM_ADD   = 12'b0000_0000_0010,
    S_MUL0     = 12'b0000_0000_0100,
    S_MUL1     = 12'b0000_0000_1000,
    S_MUL2     = 12'b0000_0001_0000,
    S_DRAW     = 12'b0000_0010_0000,
    S_CHECK    = 12'b0000_0100_0000,
    S_BOUND    = 12'b0000_1000_0000,
    S_LIM_DIV  = 12'b0001_0000_0000,
    S_LIM_SAVE = 12'b0010_0000_0000,
    S_MOD_DIV  = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  act_t              act_r, act_nxt;
  logic [WIDX_W-1:0] wi_r, wi_nxt;
  logic              cpass_r, cpass_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [TRY_W-1:0]  tries_r, tries_nxt;
  out_sel_t          osel_r, osel_nxt;
  logic              err_r, err_nxt;
  logic              ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    wi_nxt    = wi_r;
    cpass_nxt = cpass_r;
    dcnt_nxt  = dcnt_r;
    tries_nxt = tries_r;
    osel_nxt  = osel_r;
    err_nxt   = err_r;
    cmd       = '{op: CMD_IDLE, csel: cpass_r, widx: wi_r, dsrc: DIV_NEG_N,
                  osel: osel_r, err: err_r};
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op  = CMD_LOAD;
          act_nxt = action;
          case (action)
            ACT_SEED: begin
              wi_nxt    = '0;
              state_nxt = S_SM_ADD;
            end
            ACT_RAW:   state_nxt = S_DRAW;
            ACT_BOUND: state_nxt = S_BOUND;
            default: begin
              osel_nxt  = OUT_ZERO;
              err_nxt   = 1'b0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SM_ADD: begin
        cmd.op    = CMD_SM_ADD;
        cpass_nxt = 1'b0;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.op    = CMD_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = CMD_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = CMD_MUL2;
        if (!cpass_r) begin
          cpass_nxt = 1'b1;
          state_nxt = S_MUL0;
        end else if (wi_r == WIDX_W'(NWORDS - 1)) begin
          osel_nxt  = OUT_ZERO;
          err_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          wi_nxt    = wi_r + 1'b1;
          state_nxt = S_SM_ADD;
        end
      end
      S_BOUND: begin
        if (status.op_zero) begin
          osel_nxt  = OUT_ZERO;
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = CMD_DIV_START;
          cmd.dsrc  = DIV_NEG_N;
          dcnt_nxt  = '0;
          state_nxt = S_LIM_DIV;
        end
      end
      S_LIM_DIV: begin
        cmd.op   = CMD_DIV_STEP;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_LIM_SAVE;
        end
      end
      S_LIM_SAVE: begin
        cmd.op    = CMD_LIM_SAVE;
        tries_nxt = '0;
        state_nxt = S_DRAW;
      end
      S_DRAW: begin
        cmd.op    = CMD_DRAW;
        tries_nxt = tries_r + 1'b1;
        if (act_r == ACT_RAW) begin
          osel_nxt  = OUT_RAW;
          err_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.x_ge_lim || tries_r == TRY_W'(MAX_DRAWS)) begin
          cmd.op    = CMD_DIV_START;
          cmd.dsrc  = DIV_DRAW;
          dcnt_nxt  = '0;
          state_nxt = S_MOD_DIV;
        end else begin
          state_nxt = S_DRAW;
        end
      end
      S_MOD_DIV: begin
        cmd.op   = CMD_DIV_STEP;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          osel_nxt  = OUT_REM;
          err_nxt   = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.op    = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r && !out_tready;
    if (cmd.op == CMD_OUT) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      act_r    <= ACT_NONE;
      wi_r     <= '0;
      cpass_r  <= 1'b0;
      dcnt_r   <= '0;
      tries_r  <= '0;
      osel_r   <= OUT_ZERO;
      err_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      act_r    <= act_nxt;
      wi_r     <= wi_nxt;
      cpass_r  <= cpass_nxt;
      dcnt_r   <= dcnt_nxt;
      tries_r  <= tries_nxt;
      osel_r   <= osel_nxt;
      err_r    <= err_nxt;
    end
  end

  a_raw_goes_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && action == ACT_RAW) |=> state_r == S_DRAW)
    else $error("raw transfer did not start a draw");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && ovalid_r && !out_tready) |=> state_r == S_DONE)
    else $error("result overwritten while output stalled");

  a_tries_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> tries_r <= TRY_W'(MAX_DRAWS))
    else $error("draw count beyond cap");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_OUT |=> ovalid_r)
    else $error("result load without valid");

  a_zero_bound_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BOUND && status.op_zero) |=> (state_r == S_DONE && err_r))
    else $error("zero bound without error flag");

endmodule

[rtl/core/xoshiro_random_generator.sv]
// Top level of the xoshiro256** generator with splitmix64 seeding.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[1:0] action, [65:2] operand
//  out_    | out | out_tvalid/tready  | tdata[63:0] value, [64] error
//
// Seed: four splitmix steps, each two 64-bit products
// built from three 32x32 partial products on one multiplier.
// Bounded draw time is set by the bit-serial remainder unit, run once for the threshold
// and once for the result, plus one draw and check per rejected draw.
// Synchronous active-low reset clears the state words to zero; no clearing pass.
// A finished result waits in the output register while the next transfer is taken.
module xoshiro_random_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [xrg_pkg::IN_TDATA_W-1:0]       in_tdata,   // action, operand, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [xrg_pkg::OUT_TDATA_W-1:0]      out_tdata   // value, error, zero pad
);
  import xrg_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [WORD_W-1:0] value;
  logic              error;

  xrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .action     (act_t'(in_tdata[1:0])),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  xrg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .operand   (in_tdata[WORD_W+1:2]),
    .status    (status),
    .out_value (value),
    .out_error (error)
  );

  assign out_tdata = {(OUT_TDATA_W - WORD_W - 1)'(0), error, value};

endmodule

[dv/tb_xoshiro_random_generator.sv]
// Testbench for xoshiro_random_generator: seed, raw and bounded draws against a local predictor.
module tb_xoshiro_random_generator;
  import xrg_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RANDOM_REQS  = 400;
  localparam int QUIET_TAIL   = 50;
  localparam int SETTLE_CYC   = 300;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    act_t        act;
    bit [63:0]   operand;
    bit          drain;
  } gen_req_t;

  typedef struct {
    act_t        act;
    bit [63:0]   value;
    bit          error;
  } gen_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  gen_req_t     pending[$];
  gen_result_t  draws_due[$];
  gen_req_t     in_cur;
  bit [63:0]    gen_state[NWORDS];

  int in_gap = 0;
  int out_stall = 0;
  int idle_pct = 25;
  int stall_pct = 25;
  int fail_count = 0;
  int cycle_count = 0;
  int n_seed = 0, n_raw = 0, n_bound = 0, n_zero_bound = 0, n_unused = 0, n_checked = 0;

  always #(CLK_HALF) clk = ~clk;

  xoshiro_random_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [63:0] rotl64(bit [63:0] v, int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

  function automatic bit [63:0] xoshiro_next();
    bit [63:0] result;
    bit [63:0] shifted;
    result  = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
    shifted = gen_state[1] << SHIFT_S3;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= shifted;
    gen_state[3] = rotl64(gen_state[3], ROT_S3);
    return result;
  endfunction

  task automatic predict_draw(input gen_req_t r);
    gen_result_t due;
    bit [63:0]   acc;
    bit [63:0]   z;
    bit [63:0]   limit;
    bit [63:0]   x;
    bit          done;
    due.act   = r.act;
    due.value = '0;
    due.error = 1'b0;
    case (r.act)
      ACT_SEED: begin
        n_seed++;
        acc = r.operand;
        for (int i = 0; i < NWORDS; i++) begin
          acc = acc + SM_GAMMA;
          z = acc;
          z = (z ^ (z >> 30)) * SM_MUL_A;
          z = (z ^ (z >> 27)) * SM_MUL_B;
          gen_state[i] = z ^ (z >> 31);
        end
      end
      ACT_RAW: begin
        n_raw++;
        due.value = xoshiro_next();
      end
      ACT_BOUND: begin
        n_bound++;
        if (r.operand == 64'd0) begin
          n_zero_bound++;
          due.error = 1'b1;
        end else begin
          limit = (64'd0 - r.operand) % r.operand;
          x = '0;
          done = 1'b0;
          for (int t = 0; t < MAX_DRAWS && !done; t++) begin
            x = xoshiro_next();
            done = (x >= limit);
          end
          due.value = x % r.operand;
        end
      end
      default: n_unused++;
    endcase
    draws_due.push_back(due);
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic add_req(input act_t a, input bit [63:0] v, input bit drain);
    gen_req_t r;
    r.act = a;
    r.operand = v;
    r.drain = drain;
    pending.push_back(r);
  endtask

  // input side: pop pending transfers, idle in bursts, hold for drain requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_draw(in_cur);
        if ((n_seed + n_raw + n_bound + n_unused) % 40 == 0)
          idle_pct = $urandom_range(0, 2) * 25;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending.size() == 0 || (pending[0].drain && draws_due.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct) begin
          in_gap <= $urandom_range(0, 6);
          in_tvalid <= 1'b0;
        end else begin
          in_cur = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_TDATA_W - 66){1'b0}}, in_cur.operand, in_cur.act};
        end
      end
    end
  end

  // output side: check each transfer against the oldest prediction, stall in bursts
  always @(posedge clk) begin
    gen_result_t due;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (draws_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          due = draws_due.pop_front();
          n_checked++;
          if (out_tdata[63:0] !== due.value)
            report_mismatch($sformatf("%s value got %h want %h",
                                      due.act.name(), out_tdata[63:0], due.value));
          if (out_tdata[64] !== due.error)
            report_mismatch($sformatf("%s error got %b want %b",
                                      due.act.name(), out_tdata[64], due.error));
        end
        if (n_checked % 40 == 0)
          stall_pct = $urandom_range(0, 2) * 25;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, draws_due.size());
      $display("xoshiro_random_generator verification failed");
      $finish;
    end
  end

  initial begin
    bit [63:0] bound;
    int        pick;
    bit        hold;

    for (int i = 0; i < NWORDS; i++) gen_state[i] = '0;

    // unseeded state: draws stay zero, rejection runs to its cap
    add_req(ACT_BOUND, 64'd3, 1'b0);
    add_req(ACT_RAW,   64'd0, 1'b0);
    add_req(ACT_BOUND, 64'd0, 1'b0);
    add_req(ACT_NONE,  ~64'd0, 1'b0);
    add_req(ACT_BOUND, ~64'd0, 1'b0);
    add_req(ACT_BOUND, 64'h8000_0000_0000_0000, 1'b0);
    add_req(ACT_SEED,  64'd0, 1'b0);
    add_req(ACT_RAW,   ~64'd0, 1'b0);
    add_req(ACT_RAW,   64'd0, 1'b0);
    add_req(ACT_BOUND, 64'd1, 1'b0);
    add_req(ACT_BOUND, ~64'd0, 1'b0);
    add_req(ACT_BOUND, 64'h8000_0000_0000_0001, 1'b0);
    add_req(ACT_BOUND, 64'h8000_0000_0000_0000, 1'b1);
    add_req(ACT_SEED,  ~64'd0, 1'b0);
    add_req(ACT_RAW,   64'h5555_5555_5555_5555, 1'b0);
    add_req(ACT_BOUND, 64'd0, 1'b0);
    add_req(ACT_NONE,  64'd0, 1'b0);
    add_req(ACT_BOUND, 64'd2, 1'b0);
    add_req(ACT_SEED,  64'h5555_5555_5555_5555, 1'b0);
    add_req(ACT_BOUND, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_req(ACT_SEED,  64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_req(ACT_BOUND, 64'hffff_ffff_ffff_fffe, 1'b0);
    add_req(ACT_RAW,   64'd0, 1'b0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      hold = (i % 100 == 60);
      if (pick < 8) begin
        add_req(ACT_SEED, rand64(), hold);
      end else if (pick < 11) begin
        add_req(ACT_NONE, rand64(), hold);
      end else if (pick < 50) begin
        add_req(ACT_RAW, rand64(), hold);
      end else begin
        case ($urandom_range(0, 5))
          0: bound = 64'($urandom_range(1, 1000));
          1: bound = rand64();
          2: bound = 64'h8000_0000_0000_0000 + 64'($urandom_range(1, 1 << 20));
          3: bound = 64'd1 << $urandom_range(0, 63);
          4: bound = ~64'd0 - 64'($urandom_range(0, 1000));
          default: bound = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64() >> $urandom_range(0, 63);
        endcase
        add_req(ACT_BOUND, bound, hold);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid || draws_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("covered %0d transfers: %0d seeds, %0d raw, %0d bounded (%0d zero bound), %0d unused",
             n_seed + n_raw + n_bound + n_unused, n_seed, n_raw, n_bound, n_zero_bound, n_unused);
    $display("checked %0d results, %0d mismatches", n_checked, fail_count);
    if (fail_count == 0) begin
      $display("xoshiro_random_generator verification clean");
    end else begin
      $display("xoshiro_random_generator verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/xrg_pkg.sv
rtl/core/xrg_rem.sv
rtl/core/xrg_datapath.sv
rtl/core/xrg_ctrl.sv
rtl/core/xoshiro_random_generator.sv
dv/tb_xoshiro_random_generator.sv
